// ----- hw/rtl/wsdq_pkg.sv -----
package wsdq_pkg;

   localparam int DEPTH_LOG2   = 10;
   localparam int SLOT_COUNT   = 1 << DEPTH_LOG2;
   localparam int IDX_W        = DEPTH_LOG2 + 1;
   localparam int TASK_W       = 32;
   localparam int CMD_W        = 2;
   localparam int BATCH_W      = 11;
   localparam int CAP_LOG2_W   = 4;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   typedef logic [CMD_W-1:0]      cmd_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [TASK_W-1:0]     task_type;
   typedef logic [BATCH_W-1:0]    batch_type;
   typedef logic [CAP_LOG2_W-1:0] cap_log2_type;

   localparam cmd_type CMD_PUSH  = 2'd0;
   localparam cmd_type CMD_POP   = 2'd1;
   localparam cmd_type CMD_STEAL = 2'd2;
   localparam cmd_type CMD_NOP   = 2'd3;

   localparam cap_log2_type CAP_LOG2_RESET = CAP_LOG2_W'(DEPTH_LOG2);

   // Register index of capacity_log2 (byte address / 4).
   localparam logic REG_CAP_LOG2 = 1'b0;

   // Number of usable entries, with the register value clamped to 1..DEPTH_LOG2.
   function automatic idx_type cap_size(input cap_log2_type lg);
      cap_log2_type c;
      c = lg;
      if (c < CAP_LOG2_W'(1)) c = CAP_LOG2_W'(1);
      if (c > CAP_LOG2_RESET) c = CAP_LOG2_RESET;
      return idx_type'(1) << c;
   endfunction

endpackage

// ----- hw/rtl/wsdq_ifs.sv -----
interface wsdq_req_if;
   logic                valid;
   logic                ready;
   wsdq_pkg::cmd_type   cmd;
   wsdq_pkg::task_type  task_handle;
   logic                batch_last;

   modport source (output valid, cmd, task_handle, batch_last, input ready);
   modport sink   (input valid, cmd, task_handle, batch_last, output ready);
endinterface

interface wsdq_rsp_if;
   logic                valid;
   logic                ready;
   logic                ok;
   wsdq_pkg::task_type  task_out;
   wsdq_pkg::batch_type batch_accepted;

   modport source (output valid, ok, task_out, batch_accepted, input ready);
   modport sink   (input valid, ok, task_out, batch_accepted, output ready);
endinterface

// ----- hw/rtl/wsdq_ram.sv -----
module wsdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/work_stealing_deque_unit.sv -----
// Channel   Dir   Handshake      Beat carries
// req_bus   in    valid/ready    cmd, task_handle, batch_last
// rsp_bus   out   valid/ready    ok, task_out, batch_accepted
// csr_*     in    APB, pready=1  capacity_log2 at byte address 0
//
// One beat is accepted per cycle. The indexes and batch state update at the
// accepting edge. The slot read is registered in the RAM read stage, and the
// result then sits in the output register. A stalled result holds in the output
// register while one more request sits in the RAM read stage; behind that the
// request channel deasserts ready. Synchronous reset empties the deque and sets
// the capacity to the full slot count. No clearing pass is needed.
module work_stealing_deque_unit (
   input  logic                                clock,
   input  logic                                reset,
   wsdq_req_if.sink                            req_bus,
   wsdq_rsp_if.source                          rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wsdq_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [wsdq_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [wsdq_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   // Deque state.
   wsdq_pkg::idx_type      top_ff, top_in;
   wsdq_pkg::idx_type      bottom_ff, bottom_in;
   wsdq_pkg::idx_type      batch_cnt_ff, batch_cnt_in;
   logic                   blocked_ff, blocked_in;
   wsdq_pkg::cap_log2_type cap_log2_ff;

   // RAM read stage.
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_ok_ff;
   logic                   s1_read_ff;
   wsdq_pkg::batch_type    s1_acc_ff;

   // Output register.
   logic                   out_valid_ff, out_valid_in;
   logic                   out_ok_ff;
   wsdq_pkg::task_type     out_task_ff;
   wsdq_pkg::batch_type    out_acc_ff;

   logic                   accept;
   logic                   s1_adv;
   logic                   csr_wr;
   wsdq_pkg::idx_type      used;
   wsdq_pkg::idx_type      cap;
   wsdq_pkg::idx_type      mask;
   wsdq_pkg::idx_type      bottom_dec;
   logic                   nonempty;
   logic                   push_ok;
   logic                   do_read;
   logic                   op_ok;
   wsdq_pkg::batch_type    op_acc;
   logic [wsdq_pkg::DEPTH_LOG2-1:0] waddr;
   logic [wsdq_pkg::DEPTH_LOG2-1:0] raddr;
   wsdq_pkg::task_type     ram_rdata;

   assign s1_adv        = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !s1_valid_ff || s1_adv;
   assign accept        = req_bus.valid && req_bus.ready;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == wsdq_pkg::REG_CAP_LOG2);
   assign csr_pready = 1'b1;
   assign csr_prdata = wsdq_pkg::CSR_DATA_W'(cap_log2_ff);

   assign used       = bottom_ff - top_ff;
   assign cap        = wsdq_pkg::cap_size(cap_log2_ff);
   assign mask       = cap - wsdq_pkg::idx_type'(1);
   assign bottom_dec = bottom_ff - wsdq_pkg::idx_type'(1);
   assign nonempty   = (used != '0);

   assign waddr = bottom_ff[wsdq_pkg::DEPTH_LOG2-1:0] & mask[wsdq_pkg::DEPTH_LOG2-1:0];

   always_comb begin
      top_in       = top_ff;
      bottom_in    = bottom_ff;
      batch_cnt_in = batch_cnt_ff;
      blocked_in   = blocked_ff;
      push_ok      = 1'b0;
      do_read      = 1'b0;
      op_ok        = 1'b0;
      op_acc       = '0;
      raddr        = top_ff[wsdq_pkg::DEPTH_LOG2-1:0] & mask[wsdq_pkg::DEPTH_LOG2-1:0];
      case (req_bus.cmd)
         wsdq_pkg::CMD_PUSH: begin
            if (!blocked_ff && (used < cap)) begin
               push_ok   = 1'b1;
               op_ok     = 1'b1;
               bottom_in = bottom_ff + wsdq_pkg::idx_type'(1);
               if (batch_cnt_ff != '1) begin
                  batch_cnt_in = batch_cnt_ff + wsdq_pkg::idx_type'(1);
               end
            end else begin
               blocked_in = 1'b1;
            end
            op_acc = wsdq_pkg::BATCH_W'(batch_cnt_in);
            if (req_bus.batch_last) begin
               batch_cnt_in = '0;
               blocked_in   = 1'b0;
            end
         end
         wsdq_pkg::CMD_POP: begin
            raddr = bottom_dec[wsdq_pkg::DEPTH_LOG2-1:0] & mask[wsdq_pkg::DEPTH_LOG2-1:0];
            if (nonempty) begin
               do_read = 1'b1;
               op_ok   = 1'b1;
               // Taking the last entry advances top and leaves bottom alone.
               if (used == wsdq_pkg::idx_type'(1)) begin
                  top_in = top_ff + wsdq_pkg::idx_type'(1);
               end else begin
                  bottom_in = bottom_dec;
               end
            end
         end
         wsdq_pkg::CMD_STEAL: begin
            if (nonempty) begin
               do_read = 1'b1;
               op_ok   = 1'b1;
               top_in  = top_ff + wsdq_pkg::idx_type'(1);
            end
         end
         default: begin
         end
      endcase
   end

   wsdq_ram #(
      .WIDTH (wsdq_pkg::TASK_W),
      .DEPTH (wsdq_pkg::SLOT_COUNT)
   ) u_slots (
      .clock (clock),
      .we    (accept && push_ok),
      .waddr (waddr),
      .wdata (req_bus.task_handle),
      .re    (accept && do_read),
      .raddr (raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         bottom_ff    <= '0;
         batch_cnt_ff <= '0;
         blocked_ff   <= 1'b0;
         cap_log2_ff  <= wsdq_pkg::CAP_LOG2_RESET;
      end else if (csr_wr) begin
         top_ff       <= '0;
         bottom_ff    <= '0;
         batch_cnt_ff <= '0;
         blocked_ff   <= 1'b0;
         cap_log2_ff  <= csr_pwdata[wsdq_pkg::CAP_LOG2_W-1:0];
      end else if (accept) begin
         top_ff       <= top_in;
         bottom_ff    <= bottom_in;
         batch_cnt_ff <= batch_cnt_in;
         blocked_ff   <= blocked_in;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff && !s1_adv;
      if (accept) begin
         s1_valid_in = 1'b1;
      end
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      if (s1_adv && s1_valid_ff) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ok_ff   <= op_ok;
         s1_read_ff <= do_read;
         s1_acc_ff  <= op_acc;
      end
      if (s1_adv && s1_valid_ff) begin
         out_ok_ff   <= s1_ok_ff;
         out_task_ff <= s1_read_ff ? ram_rdata : '0;
         out_acc_ff  <= s1_acc_ff;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.ok             = out_ok_ff;
   assign rsp_bus.task_out       = out_task_ff;
   assign rsp_bus.batch_accepted = out_acc_ff;

   // The occupancy never exceeds the configured capacity.
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      used <= cap)
      else $error("deque occupancy above capacity");

   // An accepted push that succeeds moves bottom by exactly one.
   a_push_bottom: assert property (@(posedge clock) disable iff (reset)
      (accept && push_ok && !csr_wr) |=>
         (bottom_ff == wsdq_pkg::idx_type'($past(bottom_ff) + wsdq_pkg::idx_type'(1))))
      else $error("bottom index did not advance on push");

   // A failed or non-returning result never carries a task handle.
   a_no_task: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ok_ff) |-> (out_task_ff == '0))
      else $error("task handle on a result without ok");

   // A RAM read in flight is always for a result that is still in the read stage.
   a_read_stage: assert property (@(posedge clock) disable iff (reset)
      (accept && do_read) |=> (s1_valid_ff && s1_read_ff))
      else $error("slot read lost its request");

endmodule

// ----- dv/work_stealing_deque_unit_test.sv -----
`timescale 1ns / 100ps

module work_stealing_deque_unit_test;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int RANDOM_SEGMENTS = 8;
   localparam int OPS_PER_SEGMENT = 24;
   localparam int FULL_DRAIN_OPS  = 8;
   localparam logic [wsdq_pkg::CSR_ADDR_W-1:0] CAP_LOG2_ADDR =
      wsdq_pkg::CSR_ADDR_W'(4 * wsdq_pkg::REG_CAP_LOG2);

   typedef struct {
      wsdq_pkg::cmd_type  cmd;
      wsdq_pkg::task_type handle;
      logic               ends_batch;
   } deque_op_type;

   typedef struct {
      logic                ok;
      wsdq_pkg::task_type  task_out;
      wsdq_pkg::batch_type batch_accepted;
   } deque_result_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [wsdq_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [wsdq_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [wsdq_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   wsdq_req_if req_if ();
   wsdq_rsp_if rsp_if ();

   work_stealing_deque_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow copy of the deque.
   wsdq_pkg::task_type     slot_mem [wsdq_pkg::SLOT_COUNT];
   wsdq_pkg::idx_type      top_idx;
   wsdq_pkg::idx_type      bot_idx;
   wsdq_pkg::batch_type    batch_count;
   logic                   batch_blocked;
   wsdq_pkg::cap_log2_type cap_reg;

   deque_op_type     op_queue [$];
   deque_result_type owed_results [$];
   deque_op_type     next_op;
   deque_result_type want;
   logic             req_taken;
   int               queued_ops;
   int               accepted_ops;
   int               errors;
   int               cycles;
   int               send_idle_pct;
   int               recv_stall_pct;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("work_stealing_deque_unit test failed");
         $finish;
      end
   end

   // Usable entries, with out-of-range register values clamped.
   function automatic wsdq_pkg::idx_type usable_slots();
      wsdq_pkg::cap_log2_type lg;
      lg = cap_reg;
      if (lg == '0) lg = wsdq_pkg::CAP_LOG2_W'(1);
      if (lg > wsdq_pkg::DEPTH_LOG2) lg = wsdq_pkg::CAP_LOG2_W'(wsdq_pkg::DEPTH_LOG2);
      return wsdq_pkg::idx_type'(1) << lg;
   endfunction

   function automatic deque_result_type deque_step(input wsdq_pkg::cmd_type cmd,
                                                   input wsdq_pkg::task_type handle,
                                                   input logic ends_batch);
      deque_result_type  r;
      wsdq_pkg::idx_type used;
      wsdq_pkg::idx_type mask;
      wsdq_pkg::idx_type below;
      wsdq_pkg::idx_type sel;
      r.ok             = 1'b0;
      r.task_out       = '0;
      r.batch_accepted = '0;
      mask = usable_slots() - 1'b1;
      used = bot_idx - top_idx;
      case (cmd)
         wsdq_pkg::CMD_PUSH: begin
            if (!batch_blocked && used < usable_slots()) begin
               sel = bot_idx & mask;
               slot_mem[sel[wsdq_pkg::DEPTH_LOG2-1:0]] = handle;
               bot_idx = bot_idx + 1'b1;
               r.ok = 1'b1;
               if (batch_count != '1) batch_count = batch_count + 1'b1;
            end else begin
               // The rest of this batch stays rejected so that only a prefix gets in.
               batch_blocked = 1'b1;
            end
            r.batch_accepted = batch_count;
            if (ends_batch) begin
               batch_count   = '0;
               batch_blocked = 1'b0;
            end
         end
         wsdq_pkg::CMD_POP: begin
            if (used != 0) begin
               below      = bot_idx - 1'b1;
               sel        = below & mask;
               r.task_out = slot_mem[sel[wsdq_pkg::DEPTH_LOG2-1:0]];
               r.ok       = 1'b1;
               // Taking the last entry moves top rather than bottom.
               if (used == 1) top_idx = top_idx + 1'b1;
               else bot_idx = below;
            end
         end
         wsdq_pkg::CMD_STEAL: begin
            if (used != 0) begin
               sel        = top_idx & mask;
               r.task_out = slot_mem[sel[wsdq_pkg::DEPTH_LOG2-1:0]];
               r.ok       = 1'b1;
               top_idx    = top_idx + 1'b1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_op = op_queue.pop_front();
            req_if.valid       <= 1'b1;
            req_if.cmd         <= next_op.cmd;
            req_if.task_handle <= next_op.handle;
            req_if.batch_last  <= next_op.ends_batch;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            owed_results.push_back(deque_step(req_if.cmd, req_if.task_handle,
                                              req_if.batch_last));
            accepted_ops++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (owed_results.size() == 0) begin
               $display("%0t: result beat with nothing owed: ok %0b task_out %h count %0d",
                        $time, rsp_if.ok, rsp_if.task_out, rsp_if.batch_accepted);
               errors++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_if.ok !== want.ok) begin
                  $display("%0t: ok expected %0b got %0b", $time, want.ok, rsp_if.ok);
                  errors++;
               end
               if (rsp_if.task_out !== want.task_out) begin
                  $display("%0t: task_out expected %h got %h", $time, want.task_out,
                           rsp_if.task_out);
                  errors++;
               end
               if (rsp_if.batch_accepted !== want.batch_accepted) begin
                  $display("%0t: batch_accepted expected %0d got %0d", $time,
                           want.batch_accepted, rsp_if.batch_accepted);
                  errors++;
               end
            end
         end
      end
   end

   function automatic void add_op(input wsdq_pkg::cmd_type cmd,
                                  input wsdq_pkg::task_type handle,
                                  input logic ends_batch);
      deque_op_type op;
      op.cmd        = cmd;
      op.handle     = handle;
      op.ends_batch = ends_batch;
      op_queue.push_back(op);
      queued_ops++;
   endfunction

   // Nothing is in flight once every queued beat went in and every result came back.
   task automatic wait_idle();
      while (!(accepted_ops == queued_ops && owed_results.size() == 0)) @(negedge clock);
   endtask

   task automatic csr_access(input logic write,
                             input logic [wsdq_pkg::CSR_ADDR_W-1:0] addr,
                             input logic [wsdq_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [wsdq_pkg::CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_cap_readback();
      logic [wsdq_pkg::CSR_DATA_W-1:0] rdata;
      csr_access(1'b0, CAP_LOG2_ADDR, '0, rdata);
      if (rdata !== wsdq_pkg::CSR_DATA_W'(cap_reg)) begin
         $display("%0t: capacity_log2 read expected %0d got %0d", $time, cap_reg, rdata);
         errors++;
      end
   endtask

   task automatic set_capacity(input wsdq_pkg::cap_log2_type value);
      logic [wsdq_pkg::CSR_DATA_W-1:0] wdata;
      logic [wsdq_pkg::CSR_DATA_W-1:0] unused;
      wdata = $urandom;
      wdata[wsdq_pkg::CAP_LOG2_W-1:0] = value;
      wait_idle();
      csr_access(1'b1, CAP_LOG2_ADDR, wdata, unused);
      // A capacity write empties the deque and closes any open batch.
      cap_reg       = value;
      top_idx       = '0;
      bot_idx       = '0;
      batch_count   = '0;
      batch_blocked = 1'b0;
      check_cap_readback();
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         1:       begin send_idle_pct = 77; recv_stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  recv_stall_pct = 77; end
         3:       begin send_idle_pct = 23; recv_stall_pct = 23; end
         default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
   endtask

   // Mostly batches of pushes with random handles, mixed with pops and steals so the
   // deque keeps crossing between empty and full. Some batches never close.
   task automatic add_random_ops(input int count);
      int made;
      int len;
      int pick;
      logic closes;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            len    = $urandom_range(1, 12);
            closes = ($urandom_range(19) != 0);
            for (int k = 0; k < len; k++) begin
               add_op(wsdq_pkg::CMD_PUSH, $urandom, closes && k == len - 1);
               made++;
               if ($urandom_range(9) == 0) begin
                  add_op($urandom_range(1) ? wsdq_pkg::CMD_POP : wsdq_pkg::CMD_STEAL,
                         $urandom, 1'($urandom_range(1)));
                  made++;
               end
            end
         end else if (pick < 72) begin
            add_op(wsdq_pkg::CMD_POP, $urandom, 1'($urandom_range(1)));
            made++;
         end else if (pick < 94) begin
            add_op(wsdq_pkg::CMD_STEAL, $urandom, 1'($urandom_range(1)));
            made++;
         end else begin
            add_op(wsdq_pkg::CMD_NOP, $urandom, 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      wsdq_pkg::cap_log2_type cap_plan [RANDOM_SEGMENTS];
      cap_plan = '{4'd1, 4'd2, 4'd3, 4'd0, 4'd4, 4'd10, 4'd15, 4'd5};

      clock              = 1'b0;
      reset              = 1'b1;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      req_if.valid       = 1'b0;
      req_if.cmd         = wsdq_pkg::CMD_NOP;
      req_if.task_handle = '0;
      req_if.batch_last  = 1'b0;
      rsp_if.ready       = 1'b0;
      req_taken          = 1'b0;
      queued_ops         = 0;
      accepted_ops       = 0;
      errors             = 0;
      cycles             = 0;
      top_idx            = '0;
      bot_idx            = '0;
      batch_count        = '0;
      batch_blocked      = 1'b0;
      cap_reg            = wsdq_pkg::CAP_LOG2_RESET;
      set_idling(0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      check_cap_readback();

      // Empty deque, the unused command, handle extremes, LIFO pop, FIFO steal and
      // a pop of the last entry.
      add_op(wsdq_pkg::CMD_POP, '1, 1'b1);
      add_op(wsdq_pkg::CMD_STEAL, '1, 1'b0);
      add_op(wsdq_pkg::CMD_NOP, '1, 1'b1);
      add_op(wsdq_pkg::CMD_PUSH, '0, 1'b1);
      add_op(wsdq_pkg::CMD_PUSH, '1, 1'b1);
      add_op(wsdq_pkg::CMD_PUSH, 32'hA5A5_5A5A, 1'b1);
      add_op(wsdq_pkg::CMD_POP, $urandom, 1'b0);
      add_op(wsdq_pkg::CMD_STEAL, $urandom, 1'b0);
      add_op(wsdq_pkg::CMD_POP, $urandom, 1'b1);
      add_op(wsdq_pkg::CMD_POP, $urandom, 1'b0);
      add_op(wsdq_pkg::CMD_STEAL, $urandom, 1'b1);

      // Register value below range: two entries. A batch hits full, a steal makes
      // room, and the batch stays rejected until its last beat.
      set_capacity(4'd0);
      add_op(wsdq_pkg::CMD_PUSH, $urandom, 1'b0);
      add_op(wsdq_pkg::CMD_PUSH, $urandom, 1'b0);
      add_op(wsdq_pkg::CMD_PUSH, $urandom, 1'b0);
      add_op(wsdq_pkg::CMD_STEAL, $urandom, 1'b0);
      add_op(wsdq_pkg::CMD_PUSH, $urandom, 1'b1);
      add_op(wsdq_pkg::CMD_PUSH, $urandom, 1'b1);
      add_op(wsdq_pkg::CMD_POP, $urandom, 1'b0);
      add_op(wsdq_pkg::CMD_STEAL, $urandom, 1'b0);
      add_op(wsdq_pkg::CMD_POP, $urandom, 1'b0);
      add_op(wsdq_pkg::CMD_PUSH, $urandom, 1'b1);

      // Register value above range, written with an entry still held.
      set_capacity(4'd15);
      add_op(wsdq_pkg::CMD_STEAL, $urandom, 1'b0);

      // One batch that fills all slots and overflows, then a few pops and steals;
      // the next capacity write empties the rest.
      set_capacity(4'd10);
      set_idling(3);
      for (int k = 0; k < wsdq_pkg::SLOT_COUNT + 2; k++) begin
         add_op(wsdq_pkg::CMD_PUSH, $urandom, k == wsdq_pkg::SLOT_COUNT + 1);
      end
      for (int k = 0; k < FULL_DRAIN_OPS; k++) begin
         add_op($urandom_range(1) ? wsdq_pkg::CMD_POP : wsdq_pkg::CMD_STEAL, $urandom,
                1'($urandom_range(1)));
      end

      for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
         set_capacity(cap_plan[seg]);
         set_idling(seg % 4);
         add_random_ops(OPS_PER_SEGMENT);
      end

      wait_idle();
      repeat (8) @(negedge clock);
      if (errors == 0 && owed_results.size() == 0) begin
         $display("work_stealing_deque_unit test passed");
      end else begin
         $display("work_stealing_deque_unit test failed");
      end
      $finish;
   end

endmodule
